// ===== sv/cgs_pkg.sv =====
// shared constants, register codes and types of the coordinate grid snapper
`default_nettype none

package cgs_pkg;

   localparam int TABLE_DEPTH    = 64;
   localparam int COORD_W        = 20;
   localparam int TOL_W          = 19;
   localparam int DATA_W         = 32;
   localparam int ADDR_W         = 4;
   localparam int PIXEL_FRAC     = 16;
   localparam int DEFAULT_TOL_PX = 100;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(DEFAULT_TOL_PX * PIXEL_FRAC);

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_SEED_X = 2'd0,
      REG_SEED_Y = 2'd1,
      REG_TOL    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] seed_x;
      logic [COORD_W-1:0] seed_y;
      logic [TOL_W-1:0]   tol;
   } cfg_type;

   // word that walks down the cell chain
   typedef struct packed {
      logic               active;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic               hit_x;
      logic               hit_y;
      logic               rec_x;
      logic               rec_y;
   } carry_type;

endpackage

`default_nettype wire

// ===== sv/cgs_ifs.sv =====
// valid/ready channel interfaces for request and response words
`default_nettype none

interface cgs_req_if import cgs_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      batch_start;
   logic signed [COORD_W-1:0] rect_x;
   logic signed [COORD_W-1:0] rect_y;

   modport source (output valid, output batch_start, output rect_x, output rect_y,
                   input ready);
   modport sink   (input valid, input batch_start, input rect_x, input rect_y,
                   output ready);
endinterface

interface cgs_rsp_if import cgs_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] snapped_x;
   logic signed [COORD_W-1:0] snapped_y;
   logic                      x_was_snapped;
   logic                      y_was_snapped;
   logic                      table_overflow;

   modport source (output valid, output snapped_x, output snapped_y,
                   output x_was_snapped, output y_was_snapped, output table_overflow,
                   input ready);
   modport sink   (input valid, input snapped_x, input snapped_y,
                   input x_was_snapped, input y_was_snapped, input table_overflow,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/coordinate_grid_snapper_core.sv =====
// top level: register block, chain of table cells, result hold and output register
// request path: front register, each cell register, hold stage, output register
// one word in flight: the next request waits until the word reaches the output register,
// so a new request is taken while the previous response still waits on the output
// reset: synchronous, active high; tables hold only the seed 0, tolerance 1600 (100 px)
// no clearing pass: each cell has its own valid bits, cleared at once
`default_nettype none

module coordinate_grid_snapper_core import cgs_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   cgs_req_if.sink           req_chan,
   cgs_rsp_if.source         rsp_chan,
   input  wire               csr_psel,
   input  wire               csr_penable,
   input  wire               csr_pwrite,
   input  wire  [ADDR_W-1:0] csr_paddr,
   input  wire  [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type            cfg;
   carry_type          chain [TABLE_DEPTH+1];
   carry_type          front_ff;
   carry_type          pend_ff;
   logic               pend_valid_ff;
   logic               busy_ff;
   logic               accept;
   logic               reload;
   logic               rsp_load;
   logic               rsp_valid_ff;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_hx_ff, rsp_hy_ff, rsp_ovf_ff;
   logic [TABLE_DEPTH:0] act_vec;
   carry_type          tail;

   // configuration registers
   cgs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // one word in flight at a time
   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;
   // batch start reloads every cell in the same edge that latches the word
   assign reload         = accept && req_chan.batch_start;

   // front register feeds the head cell for exactly one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.active <= 1'b0;
      end else begin
         front_ff.active <= accept;
      end
      if (accept) begin
         front_ff.x     <= req_chan.rect_x;
         front_ff.y     <= req_chan.rect_y;
         front_ff.out_x <= req_chan.rect_x;
         front_ff.out_y <= req_chan.rect_y;
      end
      front_ff.hit_x <= 1'b0;
      front_ff.hit_y <= 1'b0;
      front_ff.rec_x <= 1'b0;
      front_ff.rec_y <= 1'b0;
   end

   assign chain[0] = front_ff;

   // cell i holds entry i of the column table and of the row table
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      cgs_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .reload  (reload),
         .is_head ((i == 0) ? 1'b1 : 1'b0),
         .seed_x  (cfg.seed_x),
         .seed_y  (cfg.seed_y),
         .tol     (cfg.tol),
         .carry_i (chain[i]),
         .carry_o (chain[i+1])
      );
   end

   for (genvar i = 0; i <= TABLE_DEPTH; i++) begin : g_act
      assign act_vec[i] = chain[i].active;
   end

   assign tail = chain[TABLE_DEPTH];

   // hold stage: keeps the finished word when the output register is still full
   assign rsp_load = pend_valid_ff && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (tail.active) begin
         pend_valid_ff <= 1'b1;
      end else if (rsp_load) begin
         pend_valid_ff <= 1'b0;
      end
      if (tail.active) begin
         pend_ff <= tail;
      end
   end

   // busy from accept until the word reaches the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (rsp_load) begin
         busy_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_x_ff   <= pend_ff.out_x;
         rsp_y_ff   <= pend_ff.out_y;
         rsp_hx_ff  <= pend_ff.hit_x;
         rsp_hy_ff  <= pend_ff.hit_y;
         // unmatched and no free slot anywhere down the chain
         rsp_ovf_ff <= (!pend_ff.hit_x && !pend_ff.rec_x) ||
                       (!pend_ff.hit_y && !pend_ff.rec_y);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.snapped_x      = rsp_x_ff;
   assign rsp_chan.snapped_y      = rsp_y_ff;
   assign rsp_chan.x_was_snapped  = rsp_hx_ff;
   assign rsp_chan.y_was_snapped  = rsp_hy_ff;
   assign rsp_chan.table_overflow = rsp_ovf_ff;

   // never more than one word walking the chain
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      $onehot0(act_vec))
      else $error("more than one word in the cell chain");

   a_busy_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("busy not set after accept");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> busy_ff)
      else $error("held word without busy");

   a_tail_free: assert property (@(posedge clock) disable iff (reset)
      tail.active |-> !pend_valid_ff)
      else $error("chain tail arrives while hold stage is full");

   a_ovf_snap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> !(rsp_hx_ff && rsp_hy_ff))
      else $error("overflow with both coordinates snapped");

endmodule

`default_nettype wire

// ===== sv/cgs_csr.sv =====
// apb-style register block: seeds and snap tolerance
`default_nettype none

module cgs_csr import cgs_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire  [ADDR_W-1:0] paddr,
   input  wire  [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_SEED_X: cfg_in.seed_x = pwdata[COORD_W-1:0];
            REG_SEED_Y: cfg_in.seed_y = pwdata[COORD_W-1:0];
            REG_TOL:    cfg_in.tol    = pwdata[TOL_W-1:0];
            default:    cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seed_x <= '0;
         cfg_ff.seed_y <= '0;
         cfg_ff.tol    <= TOL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_SEED_X: prdata = {{(DATA_W-COORD_W){cfg_ff.seed_x[COORD_W-1]}}, cfg_ff.seed_x};
         REG_SEED_Y: prdata = {{(DATA_W-COORD_W){cfg_ff.seed_y[COORD_W-1]}}, cfg_ff.seed_y};
         REG_TOL:    prdata = {{(DATA_W-TOL_W){1'b0}}, cfg_ff.tol};
         default:    prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/cgs_cell.sv =====
// one table slot of both tables: compare, first-match, append, pass word on
`default_nettype none

module cgs_cell import cgs_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  wire                reload,
   input  wire                is_head,
   input  wire  [COORD_W-1:0] seed_x,
   input  wire  [COORD_W-1:0] seed_y,
   input  wire  [TOL_W-1:0]   tol,
   input  carry_type          carry_i,
   output carry_type          carry_o
);

   logic [COORD_W-1:0] entry_x_ff, entry_y_ff;
   logic               valid_x_ff, valid_y_ff;
   carry_type          carry_ff, carry_in;
   logic [COORD_W:0]   dx, dy, adx, ady;
   logic               close_x, close_y;
   logic               rec_x, rec_y;

   // exact distance on 21 bits, magnitude fits unsigned
   assign dx  = {carry_i.x[COORD_W-1], carry_i.x} - {entry_x_ff[COORD_W-1], entry_x_ff};
   assign dy  = {carry_i.y[COORD_W-1], carry_i.y} - {entry_y_ff[COORD_W-1], entry_y_ff};
   assign adx = dx[COORD_W] ? (~dx + 1'b1) : dx;
   assign ady = dy[COORD_W] ? (~dy + 1'b1) : dy;
   assign close_x = adx <= {2'b00, tol};
   assign close_y = ady <= {2'b00, tol};

   // first free slot takes the value when nothing matched upstream
   assign rec_x = carry_i.active && !carry_i.hit_x && !carry_i.rec_x && !valid_x_ff;
   assign rec_y = carry_i.active && !carry_i.hit_y && !carry_i.rec_y && !valid_y_ff;

   always_comb begin
      carry_in = carry_i;
      if (carry_i.active && !carry_i.hit_x && valid_x_ff && close_x) begin
         carry_in.hit_x = 1'b1;
         carry_in.out_x = entry_x_ff;
      end
      if (carry_i.active && !carry_i.hit_y && valid_y_ff && close_y) begin
         carry_in.hit_y = 1'b1;
         carry_in.out_y = entry_y_ff;
      end
      if (rec_x) carry_in.rec_x = 1'b1;
      if (rec_y) carry_in.rec_y = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_x_ff <= is_head;
         valid_y_ff <= is_head;
         entry_x_ff <= '0;
         entry_y_ff <= '0;
      end else if (reload) begin
         valid_x_ff <= is_head;
         valid_y_ff <= is_head;
         entry_x_ff <= seed_x;
         entry_y_ff <= seed_y;
      end else begin
         if (rec_x) begin
            valid_x_ff <= 1'b1;
            entry_x_ff <= carry_i.x;
         end
         if (rec_y) begin
            valid_y_ff <= 1'b1;
            entry_y_ff <= carry_i.y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff.active <= 1'b0;
      end else begin
         carry_ff.active <= carry_in.active;
      end
      carry_ff.x     <= carry_in.x;
      carry_ff.y     <= carry_in.y;
      carry_ff.out_x <= carry_in.out_x;
      carry_ff.out_y <= carry_in.out_y;
      carry_ff.hit_x <= carry_in.hit_x;
      carry_ff.hit_y <= carry_in.hit_y;
      carry_ff.rec_x <= carry_in.rec_x;
      carry_ff.rec_y <= carry_in.rec_y;
   end

   assign carry_o = carry_ff;

endmodule

`default_nettype wire

// ===== bench/tb_coordinate_grid_snapper_core.sv =====
// self-checking bench for the coordinate grid snapper core: random and directed rectangles
module tb_coordinate_grid_snapper_core import cgs_pkg::*;;

   // table selector for the predictor
   localparam int AXIS_COL = 0;
   localparam int AXIS_ROW = 1;
   // register slot past the last one, writes there must be dropped
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};
   // request accepted to response valid
   localparam int LATENCY = TABLE_DEPTH + 2;

   typedef struct {
      bit                        batch;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } rect_item_type;

   typedef struct {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      bit                        hx;
      bit                        hy;
      bit                        ovf;
   } snap_result_type;

   logic clock = 1'b0;
   logic reset;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   cgs_req_if req_bus ();
   cgs_rsp_if rsp_bus ();

   coordinate_grid_snapper_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // register shadow, follows every csr write
   logic signed [COORD_W-1:0] seed_x_cfg;
   logic signed [COORD_W-1:0] seed_y_cfg;
   logic [TOL_W-1:0]          tol_cfg;

   // predictor copy of the column and row tables
   logic signed [COORD_W-1:0] grid_line [2][TABLE_DEPTH];
   int                        grid_fill [2];

   rect_item_type   pending_rects [$];
   snap_result_type expected_snaps [$];

   // stimulus bias: values already sent in the current batch
   logic signed [COORD_W-1:0] seen_cols [$];
   logic signed [COORD_W-1:0] seen_rows [$];
   int                        batch_left;

   // per-cycle idle odds, in percent
   int send_gap_pct;
   int recv_gap_pct;

   int fault_count;
   int words_checked;
   int x_snaps;
   int y_snaps;
   int overflow_words;
   int batches_sent;

   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("mismatch at %0t: %s", $time, msg);
   endfunction

   // first recorded line within tolerance wins, else record the value if there is room
   function automatic logic signed [COORD_W-1:0] snap_coord(input int axis,
         input logic signed [COORD_W-1:0] v, output bit hit, inout bit full);
      longint gap;
      int     i;
      hit = 1'b0;
      for (i = 0; i < grid_fill[axis]; i++) begin
         gap = longint'(v) - longint'(grid_line[axis][i]);
         if (gap < 0)
            gap = -gap;
         if (gap <= longint'(tol_cfg)) begin
            hit = 1'b1;
            return grid_line[axis][i];
         end
      end
      if (grid_fill[axis] < TABLE_DEPTH) begin
         grid_line[axis][grid_fill[axis]] = v;
         grid_fill[axis]++;
      end else begin
         full = 1'b1;
      end
      return v;
   endfunction

   function automatic void reload_grid();
      grid_fill[AXIS_COL] = 1;
      grid_fill[AXIS_ROW] = 1;
      grid_line[AXIS_COL][0] = seed_x_cfg;
      grid_line[AXIS_ROW][0] = seed_y_cfg;
   endfunction

   function automatic snap_result_type predict_snap(input rect_item_type r);
      snap_result_type e;
      bit hx;
      bit hy;
      bit ovf;
      ovf = 1'b0;
      if (r.batch)
         reload_grid();
      e.sx  = snap_coord(AXIS_COL, r.x, hx, ovf);
      e.sy  = snap_coord(AXIS_ROW, r.y, hy, ovf);
      e.hx  = hx;
      e.hy  = hy;
      e.ovf = ovf;
      return e;
   endfunction

   // request driver: holds a word until taken, random gaps between words
   always @(posedge clock) begin : rect_driver
      rect_item_type on_bus;
      rect_item_type nxt;
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.batch_start <= 1'b0;
         req_bus.rect_x      <= '0;
         req_bus.rect_y      <= '0;
      end else begin
         // word taken at this edge: predict from what was on the bus
         if (req_bus.valid && req_bus.ready) begin
            expected_snaps.insert(expected_snaps.size(), predict_snap(on_bus));
            if (on_bus.batch)
               batches_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_rects.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               nxt = pending_rects.pop_front();
               on_bus = nxt;
               req_bus.valid       <= 1'b1;
               req_bus.batch_start <= nxt.batch;
               req_bus.rect_x      <= nxt.x;
               req_bus.rect_y      <= nxt.y;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: random back-pressure, every taken word checked against the oldest prediction
   always @(posedge clock) begin : snap_monitor
      snap_result_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_snaps.size() == 0) begin
               log_fault($sformatf("response word with nothing pending x=%0d y=%0d",
                                   rsp_bus.snapped_x, rsp_bus.snapped_y));
            end else begin
               e = expected_snaps.pop_front();
               words_checked++;
               if (e.hx) x_snaps++;
               if (e.hy) y_snaps++;
               if (e.ovf) overflow_words++;
               if (rsp_bus.snapped_x !== e.sx || rsp_bus.snapped_y !== e.sy ||
                   rsp_bus.x_was_snapped !== e.hx || rsp_bus.y_was_snapped !== e.hy ||
                   rsp_bus.table_overflow !== e.ovf)
                  log_fault($sformatf(
                     "word %0d exp x=%0d y=%0d hx=%0b hy=%0b ovf=%0b got x=%0d y=%0d hx=%0b hy=%0b ovf=%0b",
                     words_checked, e.sx, e.sy, e.hx, e.hy, e.ovf,
                     rsp_bus.snapped_x, rsp_bus.snapped_y, rsp_bus.x_was_snapped,
                     rsp_bus.y_was_snapped, rsp_bus.table_overflow));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // apb write: setup cycle, access cycle, register takes the data at the end of access
   task automatic csr_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_SEED_X: seed_x_cfg = value[COORD_W-1:0];
         REG_SEED_Y: seed_y_cfg = value[COORD_W-1:0];
         REG_TOL:    tol_cfg    = value[TOL_W-1:0];
         default: ;
      endcase
   endtask

   // apb read, only the register's own bits are compared
   task automatic csr_check(input logic [1:0] idx, input logic [DATA_W-1:0] want,
                            input int width);
      logic [DATA_W-1:0] mask;
      mask = DATA_W'((64'd1 << width) - 1);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if ((csr_prdata & mask) !== (want & mask))
         log_fault($sformatf("register %0d read 0x%0h, expected 0x%0h", idx,
                             csr_prdata & mask, want & mask));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_regs(input logic signed [COORD_W-1:0] sx,
                               input logic signed [COORD_W-1:0] sy,
                               input logic [TOL_W-1:0] tol);
      csr_write(REG_SEED_X, {{(DATA_W-COORD_W){sx[COORD_W-1]}}, sx});
      csr_write(REG_SEED_Y, {{(DATA_W-COORD_W){sy[COORD_W-1]}}, sy});
      csr_write(REG_TOL, {{(DATA_W-TOL_W){1'b0}}, tol});
      csr_check(REG_SEED_X, DATA_W'(seed_x_cfg), COORD_W);
      csr_check(REG_SEED_Y, DATA_W'(seed_y_cfg), COORD_W);
      csr_check(REG_TOL, DATA_W'(tol_cfg), TOL_W);
   endtask

   task automatic queue_rect(input bit batch, input int x, input int y);
      rect_item_type r;
      r.batch = batch;
      r.x = COORD_W'(x);
      r.y = COORD_W'(y);
      pending_rects.insert(pending_rects.size(), r);
   endtask

   // idle point: nothing left to send, nothing on the bus, nothing outstanding;
   // sampled on the falling edge so the driver's updates have settled
   task automatic drain();
      @(negedge clock);
      while (!(pending_rects.size() == 0 && !req_bus.valid && expected_snaps.size() == 0))
         @(negedge clock);
   endtask

   // coordinate near an earlier one: on the tolerance edge, just past it, inside it,
   // or a fresh value or a range extreme now and then
   function automatic logic signed [COORD_W-1:0] pick_coord(
         input logic signed [COORD_W-1:0] base);
      int t;
      int off;
      t = int'(tol_cfg);
      off = 0;
      case ($urandom_range(9))
         0, 1, 2: return COORD_W'($urandom);
         3: begin
            case ($urandom_range(2))
               0: return COORD_MIN;
               1: return COORD_MAX;
               default: return '0;
            endcase
         end
         4: off = 0;
         5: off = $urandom_range(1) ? t : -t;
         6: off = $urandom_range(1) ? t + 1 : -(t + 1);
         7: off = $urandom_range(1) ? t + 1 + int'($urandom_range(64))
                                    : -(t + 1 + int'($urandom_range(64)));
         default: off = int'($urandom_range(2 * t)) - t;
      endcase
      return base + COORD_W'(off);
   endfunction

   // batches of random length, mostly short, some long enough to fill a table,
   // plus a stray batch start now and then
   task automatic plan_random_rects(input int count);
      rect_item_type r;
      int n;
      for (n = 0; n < count; n++) begin
         if (batch_left <= 0 || $urandom_range(99) < 3) begin
            r.batch = 1'b1;
            batch_left = ($urandom_range(4) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 40);
            seen_cols = '{seed_x_cfg};
            seen_rows = '{seed_y_cfg};
         end else begin
            r.batch = 1'b0;
         end
         batch_left--;
         r.x = pick_coord(seen_cols[$urandom_range(seen_cols.size() - 1)]);
         r.y = pick_coord(seen_rows[$urandom_range(seen_rows.size() - 1)]);
         seen_cols.insert(seen_cols.size(), r.x);
         seen_rows.insert(seen_rows.size(), r.y);
         pending_rects.insert(pending_rects.size(), r);
      end
   endtask

   initial begin : stimulus
      int sec;
      // every input known from time zero
      reset        = 1'b1;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      req_bus.valid       = 1'b0;
      req_bus.batch_start = 1'b0;
      req_bus.rect_x      = '0;
      req_bus.rect_y      = '0;
      rsp_bus.ready       = 1'b0;
      fault_count    = 0;
      words_checked  = 0;
      x_snaps        = 0;
      y_snaps        = 0;
      overflow_words = 0;
      batches_sent   = 0;
      batch_left     = 0;
      // state after reset: seeds 0, default tolerance, tables hold only the seeds
      seed_x_cfg = '0;
      seed_y_cfg = '0;
      tol_cfg    = TOL_RESET;
      reload_grid();
      seen_cols = '{seed_x_cfg};
      seen_rows = '{seed_y_cfg};
      send_gap_pct = 6;
      recv_gap_pct = 67;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset values read back, then a write to the empty slot must change nothing
      csr_check(REG_SEED_X, '0, COORD_W);
      csr_check(REG_TOL, DATA_W'(TOL_RESET), TOL_W);
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      program_regs('0, '0, TOL_RESET);

      // directed: default tolerance, seeds 0
      queue_rect(1, 0, 0);                  // exact hit on the seeds
      queue_rect(0, 1600, -1600);           // distance equals tolerance, snaps
      queue_rect(0, 1601, -1601);           // one past tolerance, recorded
      queue_rect(0, 1500, -1500);           // two lines in range, lower index wins
      queue_rect(0, -524288, 524287);       // range extremes recorded
      queue_rect(0, 524287, -524288);
      queue_rect(0, -522688, 522687);       // snaps onto the extremes
      queue_rect(0, 3201, -3201);           // snaps onto second line
      queue_rect(0, 3202, -3202);
      queue_rect(1, 1601, -1601);           // reload drops earlier lines
      queue_rect(0, 0, 1601);               // x hits while y is recorded
      drain();

      // zero tolerance: only exact matches snap
      program_regs('0, '0, '0);
      queue_rect(0, 1601, 5);
      queue_rect(0, 1602, -1601);
      drain();

      // new seeds do not touch the live tables until the next batch start
      program_regs(COORD_MAX, COORD_MIN, TOL_MAX);
      queue_rect(0, 0, 0);
      queue_rect(1, -524288, 524287);       // full-span distance never snaps
      queue_rect(0, 0, 0);
      queue_rect(0, -1, -1);
      drain();

      // random sections: idling pattern per third, register setting per section
      for (sec = 0; sec < 9; sec++) begin
         case (sec / 3)
            0: begin
               send_gap_pct = 6;
               recv_gap_pct = 67;
            end
            1: begin
               send_gap_pct = 67;
               recv_gap_pct = 6;
            end
            default: begin
               send_gap_pct = 0;
               recv_gap_pct = 0;
            end
         endcase
         case (sec)
            0: program_regs(COORD_W'($urandom), COORD_W'($urandom), TOL_RESET);
            1: program_regs('0, '0, '0);
            2: program_regs(COORD_W'($urandom), COORD_W'($urandom), TOL_W'($urandom_range(4000)));
            3: program_regs(COORD_MIN, COORD_MAX, TOL_MAX);
            4: program_regs(COORD_W'($urandom), COORD_W'($urandom), TOL_W'($urandom));
            5: program_regs(COORD_W'($urandom), COORD_W'($urandom), '0);
            6: program_regs(COORD_W'($urandom), '0, TOL_W'($urandom_range(2000)));
            7: program_regs(COORD_MAX, COORD_MIN, TOL_RESET);
            default: program_regs(COORD_W'($urandom), COORD_W'($urandom), TOL_W'($urandom));
         endcase
         plan_random_rects(92);
         drain();
      end

      // quiet tail: any stray response word still gets caught
      repeat (LATENCY + 8) @(posedge clock);
      $display("checked %0d response words over %0d batches, 9 register settings",
               words_checked, batches_sent);
      $display("x snaps %0d, y snaps %0d, words with a full table %0d, faults %0d",
               x_snaps, y_snaps, overflow_words, fault_count);
      if (fault_count == 0)
         $display("tb_coordinate_grid_snapper_core: PASS");
      else
         $display("tb_coordinate_grid_snapper_core: FAIL");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #4000000;
      $display("timeout: %0d words still outstanding", expected_snaps.size());
      $display("tb_coordinate_grid_snapper_core: FAIL");
      $finish;
   end

endmodule
